>>> rtl/nhvc_pkg.sv
// ----------------------------------------------------------------------------
// nhvc_pkg
// Types and constants shared by the nibble-header varint codec.
// ----------------------------------------------------------------------------
package nhvc_pkg;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [3:0] NIBBLE_MASK = 4'hf;
  localparam logic [3:0] MAX_TRAIL   = 4'd8;

  typedef struct packed {
    logic        is_dec;
    logic [63:0] value;
    logic [7:0]  hdr;
    logic [3:0]  cnt;
    logic        bad;
  } nhvc_cmd_t;

endpackage

>>> rtl/nibble_header_varint_codec.sv
// ----------------------------------------------------------------------------
// nibble_header_varint_codec
// Big-endian nibble-header varint encoder and decoder for 64-bit values.
//
//   channel  direction  payload
//   cfg      in         cfg_data: mode (0 encode, 1 decode)
//   s_axis   in         tdata: value_in[63:0], byte_in[71:64]
//   m_axis   out        tdata: out_byte[7:0], value_out[71:8]; tlast; tuser
//
// Encode: one item in, 1 to 9 items out at one per cycle while m_tready is
// high, set by the byte sequencer in the output stage. Decode: one byte per
// cycle while s_tready is high; each result is registered in the command
// queue, then the output register. Reset clears mode to encode and the decode
// state. Output stalls fill the command queue, then hold s_tready low.
// ----------------------------------------------------------------------------
module nibble_header_varint_codec
  import nhvc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [71:0] s_tdata,   // value_in[63:0], byte_in[71:64]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // out_byte[7:0], value_out[71:8]
  output logic        m_tlast,
  output logic        m_tuser    // malformed
);

  nhvc_cmd_t   fr_cmd;
  nhvc_cmd_t   q_cmd;
  logic        push;
  logic        pop;
  logic        q_full;
  logic        q_valid;
  logic [7:0]  out_byte;
  logic [63:0] value_out;

  nhvc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .value_in  (s_tdata[63:0]),
    .byte_in   (s_tdata[71:64]),
    .q_full    (q_full),
    .push      (push),
    .cmd       (fr_cmd)
  );

  nhvc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .wr_cmd   (fr_cmd),
    .full     (q_full),
    .pop      (pop),
    .rd_valid (q_valid),
    .rd_cmd   (q_cmd)
  );

  nhvc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_cmd     (q_cmd),
    .pop       (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (out_byte),
    .value_out (value_out),
    .last      (m_tlast),
    .malformed (m_tuser)
  );

  assign m_tdata = {value_out, out_byte};

endmodule

>>> rtl/nhvc_front.sv
// ----------------------------------------------------------------------------
// nhvc_front
// Accepts items, holds the mode and the decode state, and turns each encode
// item, and each completing decode byte, into a command for the output side.
// ----------------------------------------------------------------------------
module nhvc_front
  import nhvc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] value_in,
  input  logic [7:0]  byte_in,
  input  logic        q_full,
  output logic        push,
  output nhvc_cmd_t   cmd
);

  logic        mode;
  logic [63:0] acc;
  logic [3:0]  left;
  logic        bad;

  logic [63:0] acc_next;
  logic [3:0]  left_next;
  logic        bad_next;
  logic        dec_done;

  logic [2:0]  top_pos;
  logic        nonzero;
  logic [7:0]  top_byte;
  logic [3:0]  enc_cnt;
  logic [7:0]  enc_hdr;
  logic [63:0] aligned;
  logic [63:0] shifted_acc;
  logic        accept;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;

  always_comb begin
    top_pos = 3'd0;
    nonzero = 1'b0;
    for (int i = 0; i < 8; i++) begin
      if (value_in[8*i +: 8] != 8'd0) begin
        top_pos = 3'(i);
        nonzero = 1'b1;
      end
    end
    top_byte = value_in[{top_pos, 3'b000} +: 8];
    if (!nonzero) begin
      enc_hdr = 8'd0;
      enc_cnt = 4'd0;
    end else if (top_byte[7:4] == 4'd0) begin
      enc_hdr = {1'b0, top_pos, top_byte[3:0]};
      enc_cnt = {1'b0, top_pos};
    end else begin
      enc_hdr = {4'({1'b0, top_pos} + 4'd1), 4'd0};
      enc_cnt = 4'({1'b0, top_pos} + 4'd1);
    end
    aligned = value_in << {3'(MAX_TRAIL - enc_cnt), 3'b000};
  end

  always_comb begin
    acc_next    = acc;
    left_next   = left;
    bad_next    = bad;
    dec_done    = 1'b0;
    shifted_acc = {acc[55:0], byte_in};
    if (left == 4'd0) begin
      if (byte_in[7:4] == 4'd0) begin
        dec_done  = 1'b1;
        acc_next  = 64'd0;
        bad_next  = 1'b0;
      end else begin
        acc_next  = {60'd0, byte_in[3:0] & NIBBLE_MASK};
        bad_next  = byte_in[7:4] > MAX_TRAIL;
        left_next = byte_in[7:4];
      end
    end else begin
      left_next = left - 4'd1;
      if (left == 4'd1) begin
        dec_done = 1'b1;
        acc_next = 64'd0;
        bad_next = 1'b0;
      end else begin
        acc_next = shifted_acc;
      end
    end
  end

  always_comb begin
    cmd = '0;
    if (mode == MODE_ENCODE) begin
      cmd.is_dec = 1'b0;
      cmd.value  = aligned;
      cmd.hdr    = enc_hdr;
      cmd.cnt    = enc_cnt;
    end else begin
      cmd.is_dec = 1'b1;
      cmd.value  = (left == 4'd0) ? {60'd0, byte_in[3:0]} : shifted_acc;
      cmd.bad    = (left == 4'd0) ? 1'b0 : bad;
    end
  end

  assign push = accept && ((mode == MODE_ENCODE) || dec_done);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_ENCODE;
      acc  <= 64'd0;
      left <= 4'd0;
      bad  <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        mode <= cfg_data;
      end
      if (accept && mode == MODE_DECODE) begin
        acc  <= acc_next;
        left <= left_next;
        bad  <= bad_next;
      end
    end
  end

endmodule

>>> rtl/nhvc_queue.sv
// ----------------------------------------------------------------------------
// nhvc_queue
// Short command queue between the accept side and the output side.
// ----------------------------------------------------------------------------
module nhvc_queue
  import nhvc_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  nhvc_cmd_t wr_cmd,
  output logic      full,
  input  logic      pop,
  output logic      rd_valid,
  output nhvc_cmd_t rd_cmd
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  nhvc_cmd_t       mem [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;

  assign full     = count == CW'(DEPTH);
  assign rd_valid = count != '0;
  assign rd_cmd   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> rtl/nhvc_back.sv
// ----------------------------------------------------------------------------
// nhvc_back
// Expands commands into output items: header then trailing bytes for an
// encoded value, one item for a decoded value.
// ----------------------------------------------------------------------------
module nhvc_back
  import nhvc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  input  nhvc_cmd_t   q_cmd,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic [63:0] value_out,
  output logic        last,
  output logic        malformed
);

  logic [63:0] sh;
  logic [3:0]  cur_left;
  logic        load;

  assign load = !out_valid || out_ready;
  assign pop  = load && (cur_left == 4'd0) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cur_left  <= 4'd0;
    end else if (load) begin
      if (cur_left != 4'd0) begin
        out_valid <= 1'b1;
        cur_left  <= cur_left - 4'd1;
      end else if (q_valid) begin
        out_valid <= 1'b1;
        cur_left  <= q_cmd.cnt;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (cur_left != 4'd0) begin
        out_byte  <= sh[63:56];
        value_out <= 64'd0;
        last      <= cur_left == 4'd1;
        malformed <= 1'b0;
        sh        <= {sh[55:0], 8'd0};
      end else if (q_valid) begin
        out_byte  <= q_cmd.hdr;
        value_out <= q_cmd.is_dec ? q_cmd.value : 64'd0;
        last      <= q_cmd.cnt == 4'd0;
        malformed <= q_cmd.bad;
        sh        <= q_cmd.value;
      end
    end
  end

endmodule

>>> rtl/nhvc_checker.sv
// ----------------------------------------------------------------------------
// nhvc_checker
// Port-level checks on the codec's output stream.
// ----------------------------------------------------------------------------
module nhvc_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [71:0] m_tdata,
  input logic        m_tlast,
  input logic        m_tuser
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output item changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_bad_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast)
    else $error("malformed flag on a non-final item");

  a_bad_decoded: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[7:0] == 8'd0)
    else $error("malformed flag on an encoded byte");

endmodule

bind nibble_header_varint_codec nhvc_checker u_nhvc_checker (.*);
